>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define FDQ_ASSERT_IMP(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error("fdq assertion failed");

// next-cycle implication, disabled in reset
`define FDQ_ASSERT_NXT(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error("fdq assertion failed");

`endif

>>> sv/fdq_pkg.sv
package fdq_pkg;

    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 128;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int STORE_DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 9;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COLUMNS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_ROWS    = 1'd1;
    localparam logic [8:0] FRAME_COLUMNS_RESET = 9'd80;
    localparam logic [7:0] FRAME_ROWS_RESET    = 8'd24;

    localparam logic [2:0] COLOR_RED    = 3'd0;
    localparam logic [2:0] COLOR_YELLOW = 3'd2;
    localparam logic [2:0] COLOR_WHITE  = 3'd6;
    localparam int NUM_HUES = 6;
    localparam logic [15:0] HUE_CENTER [NUM_HUES] =
        '{16'd0, 16'd5994, 16'd3006, 16'd12006, 16'd16002, 16'd9000};
    localparam logic [7:0]  SAT_WHITE_LIMIT = 8'd40;
    localparam logic [16:0] DIST_START      = 17'd36200;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic       changed;
        logic       cursor_jump;
        logic [7:0] cursor_row;
        logic [7:0] cursor_column;
        logic [2:0] color_index;
        logic [2:0] shade_level;
        logic       frame_end;
    } result_t;

endpackage

>>> sv/fdq_if.sv
interface fdq_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
    logic [7:0] luma;

    modport source (output valid, hue, saturation, brightness, luma, input ready);
    modport sink   (input valid, hue, saturation, brightness, luma, output ready);
endinterface

interface fdq_result_if;
    logic       valid;
    logic       ready;
    logic       changed;
    logic       cursor_jump;
    logic [7:0] cursor_row;
    logic [7:0] cursor_column;
    logic [2:0] color_index;
    logic [2:0] shade_level;
    logic       frame_end;

    modport source (output valid, changed, cursor_jump, cursor_row, cursor_column,
                    color_index, shade_level, frame_end, input ready);
    modport sink   (input valid, changed, cursor_jump, cursor_row, cursor_column,
                    color_index, shade_level, frame_end, output ready);
endinterface

>>> sv/frame_diff_ansi_cell_quantizer.sv
// a result passes the compare stage, registered together with the frame store read, and then
// the result queue before it is offered
// throughput: one pixel per cycle while the result queue has room; it holds up to 4 results under output stall
// reset: counters clear at once; the frame store is then zeroed one entry a cycle,
// all 32768 entries, with the input held off; configuration writes are taken throughout
// registers reset to 80 columns and 24 rows
module frame_diff_ansi_cell_quantizer (
    input  logic                               clk,
    input  logic                               rst_n,
    fdq_pixel_if.sink                          pixel,
    fdq_result_if.source                       result,
    input  logic                               cfg_we,
    input  logic [fdq_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fdq_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import fdq_pkg::*;

    `include "assert_macros.svh"

    function automatic logic [2:0] pick_color(logic [7:0] h, logic [7:0] s);
        logic [15:0] h100;
        logic [15:0] diff;
        logic [16:0] d;
        logic [16:0] best;
        logic [2:0]  idx;
        best = DIST_START;
        idx  = COLOR_RED;
        h100 = {8'd0, h} * 16'd100;
        // white has no hue center and never wins on distance; it is picked on low saturation alone
        for (int k = 0; k < NUM_HUES; k++)
        begin
            diff = (h100 > HUE_CENTER[k]) ? h100 - HUE_CENTER[k] : HUE_CENTER[k] - h100;
            d = {diff, 1'b0};
            if (3'(k) == COLOR_YELLOW)
            begin
                d = d - 17'd1;
            end
            if (d < best)
            begin
                best = d;
                idx  = 3'(k);
            end
        end
        if (s < SAT_WHITE_LIMIT)
        begin
            idx = COLOR_WHITE;
        end
        return idx;
    endfunction

    // configuration
    logic [8:0] frame_columns_reg;
    logic [7:0] frame_rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_columns_reg <= FRAME_COLUMNS_RESET;
            frame_rows_reg    <= FRAME_ROWS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_COLUMNS: frame_columns_reg <= cfg_data;
                REG_FRAME_ROWS:    frame_rows_reg    <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    logic [8:0] cols_eff;
    logic [7:0] rows_eff;

    always_comb
    begin
        if (frame_columns_reg == '0)
            cols_eff = 9'd1;
        else if (frame_columns_reg > 9'(MAX_COLUMNS))
            cols_eff = 9'(MAX_COLUMNS);
        else
            cols_eff = frame_columns_reg;
        if (frame_rows_reg == '0)
            rows_eff = 8'd1;
        else if (frame_rows_reg > 8'(MAX_ROWS))
            rows_eff = 8'(MAX_ROWS);
        else
            rows_eff = frame_rows_reg;
    end

    // store clearing after reset
    logic                clear_active_reg;
    logic [STORE_AW-1:0] clear_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
        end
        else if (clear_active_reg)
        begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_addr_reg == STORE_AW'(STORE_DEPTH - 1))
            begin
                clear_active_reg <= 1'b0;
            end
        end
    end

    // input stage: position, counters, color and shade
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic             accept;
    logic             row_end;
    logic             frame_end;
    logic [10:0]      shade_prod;
    logic [FIFO_AW:0] fifo_count;
    logic [FIFO_AW:0] occupancy;
    logic             s1_valid_reg;

    assign occupancy   = fifo_count + {{FIFO_AW{1'b0}}, s1_valid_reg};
    assign pixel.ready = !clear_active_reg && (occupancy < (FIFO_AW+1)'(FIFO_DEPTH));
    assign accept      = pixel.valid && pixel.ready;
    assign row_end     = ({1'b0, col_reg} + 9'd1) >= cols_eff;
    assign frame_end   = row_end && (({1'b0, row_reg} + 8'd1) >= rows_eff);
    assign shade_prod  = {3'd0, pixel.brightness} * 11'd5;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            if (row_end)
            begin
                col_reg <= '0;
                row_reg <= frame_end ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // frame store: read and write the same entry in the accept cycle
    logic                ram_we;
    logic [STORE_AW-1:0] ram_waddr;
    logic [7:0]          ram_wdata;
    logic [STORE_AW-1:0] pos;
    logic [7:0]          ram_rdata;

    assign pos       = {row_reg, col_reg};
    assign ram_we    = clear_active_reg || accept;
    assign ram_waddr = clear_active_reg ? clear_addr_reg : pos;
    assign ram_wdata = clear_active_reg ? 8'd0 : pixel.luma;

    fdq_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (pos),
        .rdata (ram_rdata)
    );

    // compare stage
    logic [7:0] s1_luma_reg;
    logic [7:0] s1_row_reg;
    logic [7:0] s1_col_reg;
    logic [2:0] s1_color_reg;
    logic [2:0] s1_shade_reg;
    logic       s1_row_end_reg;
    logic       s1_frame_end_reg;
    logic       left_changed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_luma_reg      <= pixel.luma;
            s1_row_reg       <= 8'({1'b0, row_reg} + 8'd1);
            s1_col_reg       <= 8'(col_reg);
            s1_color_reg     <= pick_color(pixel.hue, pixel.saturation);
            s1_shade_reg     <= shade_prod[10:8];
            s1_row_end_reg   <= row_end;
            s1_frame_end_reg <= frame_end;
        end
    end

    logic    changed;
    result_t s1_result;

    assign changed = (ram_rdata != s1_luma_reg);

    always_comb
    begin
        s1_result               = '0;
        s1_result.changed       = changed;
        s1_result.frame_end     = s1_frame_end_reg;
        if (changed)
        begin
            s1_result.cursor_jump   = !left_changed_reg;
            s1_result.cursor_row    = s1_row_reg;
            s1_result.cursor_column = s1_col_reg;
            s1_result.color_index   = s1_color_reg;
            s1_result.shade_level   = s1_shade_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_changed_reg <= 1'b0;
        end
        else if (s1_valid_reg)
        begin
            left_changed_reg <= s1_row_end_reg ? 1'b0 : changed;
        end
    end

    // result queue
    result_t head;
    logic    out_pop;

    assign out_pop = result.valid && result.ready;

    fdq_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid_reg),
        .push_data (s1_result),
        .pop       (out_pop),
        .not_empty (result.valid),
        .head      (head),
        .count     (fifo_count)
    );

    assign result.changed       = head.changed;
    assign result.cursor_jump   = head.cursor_jump;
    assign result.cursor_row    = head.cursor_row;
    assign result.cursor_column = head.cursor_column;
    assign result.color_index   = head.color_index;
    assign result.shade_level   = head.shade_level;
    assign result.frame_end     = head.frame_end;

    `FDQ_ASSERT_IMP(a_hold_off_while_clearing, clear_active_reg, !pixel.ready)
    `FDQ_ASSERT_IMP(a_compare_follows_beat, s1_valid_reg, $past(accept))
    `FDQ_ASSERT_IMP(a_room_for_inflight, s1_valid_reg, fifo_count < (FIFO_AW+1)'(FIFO_DEPTH))
    `FDQ_ASSERT_IMP(a_unchanged_is_blank, result.valid && !result.changed,
        !result.cursor_jump && result.cursor_row == 8'd0 && result.color_index == 3'd0)

endmodule

>>> sv/fdq_ram.sv
module fdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/fdq_out_fifo.sv
module fdq_out_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  fdq_pkg::result_t        push_data,
    input  logic                    pop,
    output logic                    not_empty,
    output fdq_pkg::result_t        head,
    output logic [fdq_pkg::FIFO_AW:0] count
);
    import fdq_pkg::*;

    `include "assert_macros.svh"

    result_t            mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic [FIFO_AW:0]   count_next;

    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `FDQ_ASSERT_IMP(a_no_overflow, push && !pop, count_reg < (FIFO_AW+1)'(FIFO_DEPTH))
    `FDQ_ASSERT_IMP(a_no_underflow, pop, count_reg != '0)

endmodule
